// File: rtl/btr_pkg.sv
// ----------------------------------------------------------------------------
// btr_pkg
// shared types, constants and the 5x7 glyph table of the text renderer
// ----------------------------------------------------------------------------
package btr_pkg;

  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 240;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam int GLYPH_W   = 5;
  localparam int GLYPH_H   = 7;
  localparam int ADVANCE   = 6;
  localparam int LINE_STEP = 8;

  localparam logic [7:0] CHAR_NL          = 8'd10;
  localparam logic [7:0] CHAR_CR          = 8'd13;
  localparam logic [7:0] CHAR_FIRST       = 8'd32;
  localparam logic [7:0] CHAR_LAST        = 8'd126;
  localparam logic [7:0] CHAR_LOWER_FIRST = 8'd97;
  localparam logic [7:0] CHAR_BLANK_FIRST = 8'd123;
  localparam logic [7:0] LOWER_TO_INDEX   = 8'd64;

  typedef enum logic [0:0] {
    CFG_FOREGROUND = 1'b0,
    CFG_BACKGROUND = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       new_string;
    logic [8:0] start_x;
    logic [7:0] start_y;
  } char_in_t;

  typedef struct packed {
    logic [8:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] pixel_color;
    logic        last_pixel;
  } pixel_out_t;

  typedef logic [0:GLYPH_H-1][GLYPH_W-1:0] glyph_t;

  // one drawable character handed from the front end to the scanner
  typedef struct packed {
    glyph_t                 glyph;
    logic [8:0]             base_x;
    logic [7:0]             base_y;
    logic [GLYPH_W-1:0]     col_mask;
    logic [GLYPH_H-1:0]     row_mask;
    logic [2:0]             last_col;
    logic [2:0]             last_row;
  } job_t;

  function automatic glyph_t glyph_lookup(input logic [6:0] idx);
    glyph_t g;
    case (idx)
      7'd0:  g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
      7'd1:  g = {5'h00, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
      7'd2:  g = {5'h00, 5'h0A, 5'h0A, 5'h0A, 5'h00, 5'h00, 5'h00};
      7'd3:  g = {5'h00, 5'h0A, 5'h1F, 5'h0A, 5'h1F, 5'h0A, 5'h00};
      7'd4:  g = {5'h04, 5'h0E, 5'h14, 5'h0E, 5'h05, 5'h0E, 5'h04};
      7'd5:  g = {5'h18, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h03};
      7'd6:  g = {5'h0C, 5'h12, 5'h12, 5'h0C, 5'h12, 5'h12, 5'h0D};
      7'd7:  g = {5'h00, 5'h04, 5'h04, 5'h04, 5'h00, 5'h00, 5'h00};
      7'd8:  g = {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02};
      7'd9:  g = {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08};
      7'd10: g = {5'h04, 5'h15, 5'h0E, 5'h04, 5'h0E, 5'h15, 5'h04};
      7'd11: g = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
      7'd12: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h08};
      7'd13: g = {5'h00, 5'h00, 5'h00, 5'h0E, 5'h00, 5'h00, 5'h00};
      7'd14: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04};
      7'd15: g = {5'h00, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00};
      7'd16: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      7'd17: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      7'd18: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      7'd19: g = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
      7'd20: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      7'd21: g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      7'd22: g = {5'h0E, 5'h11, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      7'd23: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10};
      7'd24: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      7'd25: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h11, 5'h0E};
      7'd26: g = {5'h00, 5'h04, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00};
      7'd27: g = {5'h00, 5'h04, 5'h00, 5'h00, 5'h00, 5'h04, 5'h08};
      7'd28: g = {5'h02, 5'h04, 5'h08, 5'h10, 5'h08, 5'h04, 5'h02};
      7'd29: g = {5'h00, 5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00};
      7'd30: g = {5'h08, 5'h04, 5'h02, 5'h01, 5'h02, 5'h04, 5'h08};
      7'd31: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
      7'd32: g = {5'h0E, 5'h11, 5'h17, 5'h15, 5'h17, 5'h10, 5'h0E};
      7'd33: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      7'd34: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      7'd35: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      7'd36: g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      7'd37: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      7'd38: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      7'd39: g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
      7'd40: g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      7'd41: g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      7'd42: g = {5'h01, 5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h0E};
      7'd43: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      7'd44: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      7'd45: g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      7'd46: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      7'd47: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      7'd48: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      7'd49: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      7'd50: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      7'd51: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      7'd52: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      7'd53: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      7'd54: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      7'd55: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
      7'd56: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      7'd57: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      7'd58: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      7'd59: g = {5'h0E, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0E};
      7'd60: g = {5'h10, 5'h10, 5'h08, 5'h04, 5'h02, 5'h01, 5'h01};
      7'd61: g = {5'h0E, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h0E};
      7'd62: g = {5'h04, 5'h0A, 5'h11, 5'h00, 5'h00, 5'h00, 5'h00};
      7'd63: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F};
      7'd64: g = {5'h08, 5'h04, 5'h02, 5'h00, 5'h00, 5'h00, 5'h00};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// File: rtl/btr_front.sv
// ----------------------------------------------------------------------------
// btr_front
// takes character transfers, keeps the cursor, clips and queues drawable cells
// ----------------------------------------------------------------------------
module btr_front #(
  parameter int SCREEN_WIDTH  = btr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = btr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  btr_pkg::char_in_t in_data_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output btr_pkg::job_t     q_data_o
);

  localparam logic [15:0] WIDTH16  = 16'(SCREEN_WIDTH);
  localparam logic [15:0] HEIGHT16 = 16'(SCREEN_HEIGHT);

  logic [15:0] cursor_x_q, cursor_x_d;
  logic [15:0] cursor_y_q, cursor_y_d;
  logic [8:0]  line_start_q, line_start_d;

  logic                       accept;
  logic [15:0]                eff_x, eff_y, adv_x;
  logic [8:0]                 eff_ls;
  logic                       drawable;
  logic [6:0]                 glyph_idx;
  logic [btr_pkg::GLYPH_W-1:0] col_mask;
  logic [btr_pkg::GLYPH_H-1:0] row_mask;
  logic [2:0]                 last_col, last_row;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    eff_x  = in_data_i.new_string ? {7'd0, in_data_i.start_x} : cursor_x_q;
    eff_y  = in_data_i.new_string ? {8'd0, in_data_i.start_y} : cursor_y_q;
    eff_ls = in_data_i.new_string ? in_data_i.start_x : line_start_q;
    adv_x  = eff_x + 16'(btr_pkg::ADVANCE);
  end

  // cursor update
  always_comb begin
    cursor_x_d   = cursor_x_q;
    cursor_y_d   = cursor_y_q;
    line_start_d = line_start_q;
    if (accept) begin
      line_start_d = eff_ls;
      if (in_data_i.char_code == btr_pkg::CHAR_NL) begin
        cursor_x_d = {7'd0, eff_ls};
        cursor_y_d = eff_y + 16'(btr_pkg::LINE_STEP);
      end else if (in_data_i.char_code == btr_pkg::CHAR_CR) begin
        cursor_x_d = {7'd0, eff_ls};
        cursor_y_d = eff_y;
      end else if (({1'b0, adv_x} + 17'(btr_pkg::GLYPH_W)) >= {1'b0, WIDTH16}) begin
        cursor_x_d = {7'd0, eff_ls};
        cursor_y_d = eff_y + 16'(btr_pkg::LINE_STEP);
      end else begin
        cursor_x_d = adv_x;
        cursor_y_d = eff_y;
      end
    end
  end

  // classification, glyph fetch and clip masks
  always_comb begin
    drawable = (in_data_i.char_code >= btr_pkg::CHAR_FIRST) &&
               (in_data_i.char_code <= btr_pkg::CHAR_LAST);
    if (in_data_i.char_code >= btr_pkg::CHAR_BLANK_FIRST) begin
      glyph_idx = '0;
    end else if (in_data_i.char_code >= btr_pkg::CHAR_LOWER_FIRST) begin
      glyph_idx = 7'(in_data_i.char_code - btr_pkg::LOWER_TO_INDEX);
    end else begin
      glyph_idx = 7'(in_data_i.char_code - btr_pkg::CHAR_FIRST);
    end
    last_col = '0;
    last_row = '0;
    for (int c = 0; c < btr_pkg::GLYPH_W; c++) begin
      col_mask[c] = (eff_x + 16'(c)) < WIDTH16;
      if (col_mask[c]) last_col = 3'(c);
    end
    for (int r = 0; r < btr_pkg::GLYPH_H; r++) begin
      row_mask[r] = (eff_y + 16'(r)) < HEIGHT16;
      if (row_mask[r]) last_row = 3'(r);
    end
  end

  assign q_push_o = accept && drawable && (|col_mask) && (|row_mask);

  always_comb begin
    q_data_o.glyph    = btr_pkg::glyph_lookup(glyph_idx);
    q_data_o.base_x   = eff_x[8:0];
    q_data_o.base_y   = eff_y[7:0];
    q_data_o.col_mask = col_mask;
    q_data_o.row_mask = row_mask;
    q_data_o.last_col = last_col;
    q_data_o.last_row = last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q   <= '0;
      cursor_y_q   <= '0;
      line_start_q <= '0;
    end else begin
      cursor_x_q   <= cursor_x_d;
      cursor_y_q   <= cursor_y_d;
      line_start_q <= line_start_d;
    end
  end

endmodule

// File: rtl/btr_queue.sv
// ----------------------------------------------------------------------------
// btr_queue
// short first-in first-out buffer of drawable cells between front and scanner
// ----------------------------------------------------------------------------
module btr_queue #(
  parameter int DEPTH = btr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  btr_pkg::job_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output btr_pkg::job_t data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  btr_pkg::job_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: rtl/btr_scan.sv
// ----------------------------------------------------------------------------
// btr_scan
// walks each 5x7 cell row by row and sends the unclipped pixels out
// ----------------------------------------------------------------------------
module btr_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  btr_pkg::job_t       q_data_i,
  output logic                q_pop_o,
  input  logic [15:0]         fg_color_i,
  input  logic [15:0]         bg_color_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output btr_pkg::pixel_out_t out_data_o
);

  localparam logic [2:0] COL_END = 3'(btr_pkg::GLYPH_W - 1);
  localparam logic [2:0] ROW_END = 3'(btr_pkg::GLYPH_H - 1);

  btr_pkg::job_t       job_q, job_d;
  logic                busy_q, busy_d;
  logic [2:0]          row_q, row_d;
  logic [2:0]          col_q, col_d;
  btr_pkg::pixel_out_t out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic       out_free, advance, at_end, pix_ok, glyph_bit;
  logic [2:0] bit_idx;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign advance   = busy_q && out_free;
  assign at_end    = (row_q == ROW_END) && (col_q == COL_END);
  assign pix_ok    = job_q.col_mask[col_q] && job_q.row_mask[row_q];
  assign bit_idx   = COL_END - col_q;
  assign glyph_bit = job_q.glyph[row_q][bit_idx];
  assign q_pop_o   = q_valid_i && (!busy_q || (advance && at_end));

  // cell position
  always_comb begin
    job_d  = job_q;
    busy_d = busy_q;
    row_d  = row_q;
    col_d  = col_q;
    if (q_pop_o) begin
      job_d  = q_data_i;
      busy_d = 1'b1;
      row_d  = '0;
      col_d  = '0;
    end else if (advance && at_end) begin
      busy_d = 1'b0;
    end else if (advance) begin
      if (col_q == COL_END) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (advance && pix_ok) begin
      out_valid_d       = 1'b1;
      out_d.pixel_x     = job_q.base_x + 9'(col_q);
      out_d.pixel_y     = job_q.base_y + 8'(row_q);
      out_d.pixel_color = glyph_bit ? fg_color_i : bg_color_i;
      out_d.last_pixel  = (row_q == job_q.last_row) && (col_q == job_q.last_col);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (row_q <= ROW_END) && (col_q <= COL_END))
    else $error("scan position outside the cell");

  a_idle_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && at_end && !q_valid_i) |=> !busy_q)
    else $error("scanner still busy after its last position");

  a_pop_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> busy_q && (row_q == '0) && (col_q == '0))
    else $error("new cell did not start at its first position");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && out_valid_q && out_stall_i) |=> $stable(row_q) && $stable(col_q))
    else $error("scan moved while output stalled");
`endif

endmodule

// File: rtl/bitmap_text_renderer.sv
// ----------------------------------------------------------------------------
// bitmap_text_renderer
// 5x7 character generator: one character in, up to 35 coloured pixels out
// ----------------------------------------------------------------------------
// Each character transfer taken by the front end updates the cursor (newline,
// carriage return, advance and right-edge wrap), clips the cell against the
// screen and queues drawable characters. The scanner then walks every cell
// position of each queued character, one cell position per cycle unless the
// output stalls, whether or not that position is on screen. Control codes,
// non-printable codes and fully clipped characters never reach the scanner.
// Up to QUEUE_DEPTH characters (two by default) can wait in the queue while a
// cell is scanned, so new characters can be taken before the last is drawn.
// Colours are set through the configuration port, which is always ready; no
// clearing pass after reset.
module bitmap_text_renderer #(
  parameter int SCREEN_WIDTH  = btr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = btr_pkg::SCREEN_HEIGHT_DEF,
  parameter int QUEUE_DEPTH   = btr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  btr_pkg::char_in_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output btr_pkg::pixel_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  btr_pkg::cfg_idx_e   cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  logic [15:0]   fg_q, bg_q;
  logic          q_full, q_push, q_valid, q_pop;
  btr_pkg::job_t q_wr_data, q_rd_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= 16'hFFFF;
      bg_q <= 16'h0000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        btr_pkg::CFG_FOREGROUND: fg_q <= cfg_data_i;
        btr_pkg::CFG_BACKGROUND: bg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  btr_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wr_data)
  );

  btr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wr_data),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_rd_data)
  );

  btr_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rd_data),
    .q_pop_o     (q_pop),
    .fg_color_i  (fg_q),
    .bg_color_i  (bg_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
